// ===== rtl/prc_pkg.sv =====
// Shared constants, register indexes and the trig table helpers for the point rotator.
package prc_pkg;

	localparam int COORD_BITS_DEF     = 19;
	localparam int TRIG_FRAC_BITS_DEF = 16;
	localparam int CENTER_W           = 17;
	localparam int CFG_INDEX_W        = 1;
	localparam int QTAB_N             = 64;

	localparam logic [CENTER_W-1:0]    CENTER_RESET = 17'd50000;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 1'b1;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// Q30 product of a series term and the squared angle.
	// These are evaluated only with constant arguments, while the design elaborates.
	function automatic logic [63:0] taylor_mul(input logic [63:0] term, input logic [63:0] x2);
		return (term * x2) >> 30;
	endfunction

	// Difference of the positive and negative series sums, rounded to frac fraction bits.
	function automatic logic [31:0] trig_round(input logic [63:0] pos, input logic [63:0] neg,
		input int unsigned frac);
		logic [63:0] v;
		v = (pos >= neg) ? pos - neg : 64'd0;
		v = (v + (64'd1 << (29 - frac))) >> (30 - frac);
		return v[31:0];
	endfunction

endpackage

// ===== rtl/prc_in_if.sv =====
// Input channel of the point rotator: one point and an angle per beat.
interface prc_in_if #(
	parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_in;
	logic signed [COORD_BITS-1:0] y_in;
	logic [7:0]                   angle;

	modport source (output valid, output x_in, output y_in, output angle, input ready);
	modport sink (input valid, input x_in, input y_in, input angle, output ready);
endinterface

// ===== rtl/prc_out_if.sv =====
// Output channel of the point rotator: one rotated point per beat.
interface prc_out_if #(
	parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_out;
	logic signed [COORD_BITS-1:0] y_out;

	modport source (output valid, output x_out, output y_out, input ready);
	modport sink (input valid, input x_out, input y_out, output ready);
endinterface

// ===== rtl/point_rotate_about_center.sv =====
// Rotates a point about a programmable center by angle/256 of a turn. Each beat on the
// input channel gives exactly one beat on the output channel, in order. The block is a
// four-stage pipeline (offset and table lookup, the four multiplies, the sums with the
// floor shift, then the center add with saturation), and a new beat is taken every
// cycle while the output side keeps up. Quarter-turn angles take exact swap and negate
// paths; all others use a sine and cosine table built at elaboration with
// TRIG_FRAC_BITS fraction bits. Results outside the signed coordinate range saturate.
// The center registers may be written only while no beat is in flight.
module point_rotate_about_center #(
	parameter int COORD_BITS     = prc_pkg::COORD_BITS_DEF,
	parameter int TRIG_FRAC_BITS = prc_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [prc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [prc_pkg::CENTER_W-1:0]     cfg_wdata,
	prc_in_if.sink                           point,
	prc_out_if.source                        result
);
	import prc_pkg::*;

	localparam int D  = ((COORD_BITS > CENTER_W + 1) ? COORD_BITS : CENTER_W + 1) + 1;
	localparam int TW = TRIG_FRAC_BITS + 1;
	localparam int CW = TRIG_FRAC_BITS + 2;
	localparam int P  = D + CW;
	localparam int SW = P + 1;
	localparam int O  = D + 3;
	localparam int RW = O + 1;

	typedef enum logic [4:0] {
		ROT_GEN = 5'b00001,
		ROT_0   = 5'b00010,
		ROT_90  = 5'b00100,
		ROT_180 = 5'b01000,
		ROT_270 = 5'b10000
	} rot_kind_t;

	localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
	localparam logic signed [RW-1:0] SAT_LO = -RW'(64'd1 << (COORD_BITS - 1));

	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;

	logic [TW-1:0] sin_tab [QTAB_N];
	logic [TW-1:0] cos_tab [QTAB_N];

	// Taylor terms in Q30; each term is the previous one times the squared angle,
	// divided by the next two factorial factors.
	for (genvar g = 0; g < QTAB_N; g++) begin : g_trig
		localparam logic [63:0] XA   = (64'(g) * PI_Q30) / 64'd128;
		localparam logic [63:0] XX   = taylor_mul(XA, XA);
		localparam logic [63:0] SN1  = taylor_mul(XA, XX) / 64'd6;
		localparam logic [63:0] SN2  = taylor_mul(SN1, XX) / 64'd20;
		localparam logic [63:0] SN3  = taylor_mul(SN2, XX) / 64'd42;
		localparam logic [63:0] SN4  = taylor_mul(SN3, XX) / 64'd72;
		localparam logic [63:0] SN5  = taylor_mul(SN4, XX) / 64'd110;
		localparam logic [63:0] SN6  = taylor_mul(SN5, XX) / 64'd156;
		localparam logic [63:0] SN7  = taylor_mul(SN6, XX) / 64'd210;
		localparam logic [63:0] SN8  = taylor_mul(SN7, XX) / 64'd272;
		localparam logic [63:0] SN9  = taylor_mul(SN8, XX) / 64'd342;
		localparam logic [63:0] SN10 = taylor_mul(SN9, XX) / 64'd420;
		localparam logic [63:0] CS1  = taylor_mul(ONE_Q30, XX) / 64'd2;
		localparam logic [63:0] CS2  = taylor_mul(CS1, XX) / 64'd12;
		localparam logic [63:0] CS3  = taylor_mul(CS2, XX) / 64'd30;
		localparam logic [63:0] CS4  = taylor_mul(CS3, XX) / 64'd56;
		localparam logic [63:0] CS5  = taylor_mul(CS4, XX) / 64'd90;
		localparam logic [63:0] CS6  = taylor_mul(CS5, XX) / 64'd132;
		localparam logic [63:0] CS7  = taylor_mul(CS6, XX) / 64'd182;
		localparam logic [63:0] CS8  = taylor_mul(CS7, XX) / 64'd240;
		localparam logic [63:0] CS9  = taylor_mul(CS8, XX) / 64'd306;
		localparam logic [63:0] CS10 = taylor_mul(CS9, XX) / 64'd380;
		localparam logic [TW-1:0] SIN_V = TW'(trig_round(XA + SN2 + SN4 + SN6 + SN8 + SN10,
			SN1 + SN3 + SN5 + SN7 + SN9, TRIG_FRAC_BITS));
		localparam logic [TW-1:0] COS_V = TW'(trig_round(ONE_Q30 + CS2 + CS4 + CS6 + CS8 + CS10,
			CS1 + CS3 + CS5 + CS7 + CS9, TRIG_FRAC_BITS));
		assign sin_tab[g] = SIN_V;
		assign cos_tab[g] = COS_V;
	end

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [D-1:0]  dx_s1, dy_s1;
	logic signed [CW-1:0] sin_s1, cos_s1;
	rot_kind_t            kind_s1;

	logic signed [D-1:0]  dx_s2, dy_s2;
	logic signed [P-1:0]  dxc_s2, dys_s2, dyc_s2, dxs_s2;
	rot_kind_t            kind_s2;

	logic signed [O-1:0]  offx_s3, offy_s3;
	logic signed [COORD_BITS-1:0] x_out_s4, y_out_s4;

	logic signed [D-1:0]  xe, ye, cxe, cye;
	logic [5:0]           tab_r;
	logic [TW-1:0]        sin_q, cos_q;
	logic signed [CW-1:0] sin_c, cos_c;
	rot_kind_t            kind_c;

	logic signed [SW-1:0] sum_x, sum_y, sh_x, sh_y;
	logic signed [O-1:0]  offx_c, offy_c, dxo, dyo;
	logic signed [RW-1:0] rx, ry, cxr, cyr;

	assign en4 = !v_s4 || result.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign point.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_RESET;
			center_y_q <= CENTER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		xe = D'(point.x_in);
		ye = D'(point.y_in);
		cxe = signed'(D'({1'b0, center_x_q}));
		cye = signed'(D'({1'b0, center_y_q}));
		tab_r = point.angle[5:0];
		sin_q = sin_tab[tab_r];
		cos_q = cos_tab[tab_r];
		unique case (point.angle[7:6])
			2'd0: begin
				sin_c = signed'(CW'(sin_q));
				cos_c = signed'(CW'(cos_q));
			end
			2'd1: begin
				sin_c = signed'(CW'(cos_q));
				cos_c = -signed'(CW'(sin_q));
			end
			2'd2: begin
				sin_c = -signed'(CW'(sin_q));
				cos_c = -signed'(CW'(cos_q));
			end
			2'd3: begin
				sin_c = -signed'(CW'(cos_q));
				cos_c = signed'(CW'(sin_q));
			end
			default: begin
				sin_c = '0;
				cos_c = '0;
			end
		endcase
		unique case (point.angle)
			8'd0:    kind_c = ROT_0;
			8'd64:   kind_c = ROT_90;
			8'd128:  kind_c = ROT_180;
			8'd192:  kind_c = ROT_270;
			default: kind_c = ROT_GEN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= point.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1 <= xe - cxe;
			dy_s1 <= ye - cye;
			sin_s1 <= sin_c;
			cos_s1 <= cos_c;
			kind_s1 <= kind_c;
		end
		if (en2) begin
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			dxc_s2 <= dx_s1 * cos_s1;
			dys_s2 <= dy_s1 * sin_s1;
			dyc_s2 <= dy_s1 * cos_s1;
			dxs_s2 <= dx_s1 * sin_s1;
			kind_s2 <= kind_s1;
		end
		if (en3) begin
			offx_s3 <= offx_c;
			offy_s3 <= offy_c;
		end
		if (en4) begin
			x_out_s4 <= COORD_BITS'(rx > SAT_HI ? SAT_HI : (rx < SAT_LO ? SAT_LO : rx));
			y_out_s4 <= COORD_BITS'(ry > SAT_HI ? SAT_HI : (ry < SAT_LO ? SAT_LO : ry));
		end
	end

	// The arithmetic shift floors, so negative sums round toward minus infinity.
	always_comb begin
		sum_x = SW'(dxc_s2) - SW'(dys_s2);
		sum_y = SW'(dyc_s2) + SW'(dxs_s2);
		sh_x = sum_x >>> TRIG_FRAC_BITS;
		sh_y = sum_y >>> TRIG_FRAC_BITS;
		dxo = O'(dx_s2);
		dyo = O'(dy_s2);
		unique case (kind_s2)
			ROT_0: begin
				offx_c = dxo;
				offy_c = dyo;
			end
			ROT_90: begin
				offx_c = -dyo;
				offy_c = dxo;
			end
			ROT_180: begin
				offx_c = -dxo;
				offy_c = -dyo;
			end
			ROT_270: begin
				offx_c = dyo;
				offy_c = -dxo;
			end
			default: begin
				offx_c = O'(sh_x);
				offy_c = O'(sh_y);
			end
		endcase
	end

	always_comb begin
		cxr = signed'(RW'({1'b0, center_x_q}));
		cyr = signed'(RW'({1'b0, center_y_q}));
		rx = cxr + RW'(offx_s3);
		ry = cyr + RW'(offy_s3);
	end

	assign result.valid = v_s4;
	assign result.x_out = x_out_s4;
	assign result.y_out = y_out_s4;

endmodule
